// ----- rtl/core/psf_pkg.sv -----
// Package for the PNG scanline filter: register codes, filter codes and beat types.
// Used by every module under rtl/core; depends on nothing else.
package psf_pkg;

  localparam int LINE_MAX_DEF   = 4096;
  localparam int HIST_DEPTH_DEF = 8;

  localparam int MODE_W     = 2;
  localparam int BPP_W      = 4;
  localparam int LEN_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [MODE_W-1:0] MODE_RESET = '0;
  localparam logic [BPP_W-1:0]  BPP_RESET  = BPP_W'(1);
  localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(4096);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_MODE     = 2'd0,
    REG_BYTES_PER_PIXEL = 2'd1,
    REG_LINE_LENGTH     = 2'd2
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    FILT_SUB  = 2'd0,
    FILT_UP   = 2'd1,
    FILT_AVG  = 2'd2,
    FILT_NONE = 2'd3
  } filter_e;

  typedef struct packed {
    logic [MODE_W-1:0] filter_mode;
    logic [BPP_W-1:0]  bytes_per_pixel;
    logic [LEN_W-1:0]  line_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] filtered_byte;
    logic       row_end;
  } out_beat_t;

  // Work carried from the front stage to the output stage.
  typedef struct packed {
    logic [7:0] raw_byte;
    logic [7:0] left_byte;
    logic       first_row;
    logic       row_end;
  } s1_t;

endpackage

// ----- rtl/core/png_scanline_filter_core.sv -----
// PNG scanline filter (None, Sub, Up, Average), one raw byte in and one filtered byte out.
// Top level; instantiates psf_cfg_regs, psf_front, psf_line_store and psf_out_stage.
// Usage:
//   Raw image bytes enter in row order on in_valid_i / in_stall_o / in_data_i.
//   Set frame_start on the first byte of each image. Each input beat yields one
//   output beat on out_valid_o / out_stall_i / out_data_o, carrying the filtered
//   byte and a row_end flag on the last byte of each row.
//   Registers (filter mode, bytes per pixel, line length) are written through
//   cfg_we_i / cfg_idx_i / cfg_wdata_i while no beat is in flight.
// Timing:
//   An accepted beat is held in the front stage, then in the output register,
//   before it is offered. Throughput is one byte per cycle while out_stall_i
//   is low; the line store is read and written at the same column on acceptance.
// Reset:
//   Registers return to Sub, one byte per pixel and 4096 bytes per row; the
//   column returns to zero and the next row counts as a first row. The line
//   store is not cleared; its contents are used only after a row has written them.
// Backpressure:
//   With out_stall_i high, one finished beat waits in the output register and
//   one more beat is accepted into the front stage; then in_stall_o rises.
module png_scanline_filter_core #(
  parameter int LINE_MAX      = psf_pkg::LINE_MAX_DEF,
  parameter int HISTORY_DEPTH = psf_pkg::HIST_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  psf_pkg::in_beat_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output psf_pkg::out_beat_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [psf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [psf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int CW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

  psf_pkg::cfg_t cfg;
  psf_pkg::s1_t  s1;
  logic          s1_valid;
  logic          take;
  logic          mem_en;
  logic [CW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  psf_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  psf_front #(
    .LINE_MAX      (LINE_MAX),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .CW            (CW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .cfg_i       (cfg),
    .take_i      (take),
    .s1_valid_o  (s1_valid),
    .s1_o        (s1),
    .mem_en_o    (mem_en),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata)
  );

  psf_line_store #(
    .DEPTH (LINE_MAX),
    .AW    (CW)
  ) u_line_store (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  psf_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s1_valid_i    (s1_valid),
    .s1_i          (s1),
    .above_raw_i   (mem_rdata),
    .filter_mode_i (cfg.filter_mode),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .out_data_o    (out_data_o),
    .out_stall_i   (out_stall_i)
  );

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid && out_valid_o && out_stall_i)
    else $error("Input stalled while the pipeline had room.");

endmodule

// ----- rtl/core/psf_cfg_regs.sv -----
// Configuration registers of the PNG scanline filter.
// Depends on psf_pkg for register codes, widths and reset values.
module psf_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [psf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [psf_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output psf_pkg::cfg_t                      cfg_o
);

  psf_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (psf_pkg::cfg_reg_e'(cfg_idx_i))
        psf_pkg::REG_FILTER_MODE: begin
          cfg_d.filter_mode = cfg_wdata_i[psf_pkg::MODE_W-1:0];
        end
        psf_pkg::REG_BYTES_PER_PIXEL: begin
          cfg_d.bytes_per_pixel = cfg_wdata_i[psf_pkg::BPP_W-1:0];
        end
        psf_pkg::REG_LINE_LENGTH: begin
          cfg_d.line_length = cfg_wdata_i[psf_pkg::LEN_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_mode     <= psf_pkg::MODE_RESET;
      cfg_q.bytes_per_pixel <= psf_pkg::BPP_RESET;
      cfg_q.line_length     <= psf_pkg::LEN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/psf_line_store.sv -----
// Line store holding the previous scanline, one byte per column.
// Synchronous memory with a registered read, read before write.
module psf_line_store #(
  parameter int DEPTH = psf_pkg::LINE_MAX_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // The read returns the byte of the previous row before this beat overwrites it.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q      <= mem_q[addr_i];
      mem_q[addr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/psf_front.sv -----
// Front stage: column tracking, left-byte history and line store addressing.
// Depends on psf_pkg for beat types and configuration.
module psf_front #(
  parameter int LINE_MAX      = psf_pkg::LINE_MAX_DEF,
  parameter int HISTORY_DEPTH = psf_pkg::HIST_DEPTH_DEF,
  parameter int CW            = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  psf_pkg::in_beat_t in_data_i,
  output logic              in_stall_o,
  input  psf_pkg::cfg_t     cfg_i,
  input  logic              take_i,
  output logic              s1_valid_o,
  output psf_pkg::s1_t      s1_o,
  output logic              mem_en_o,
  output logic [CW-1:0]     mem_addr_o,
  output logic [7:0]        mem_wdata_o
);

  localparam int HW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int IW  = HW + 2;
  localparam int LW  = $clog2(LINE_MAX + 1);
  localparam int LW1 = LW + 1;

  logic [CW-1:0]   col_q, col_d, col;
  logic            first_q, first_d, first;
  logic [HW-1:0]   hptr_q, hptr_d, hptr;
  logic [7:0]      hist_q [HISTORY_DEPTH];
  logic            s1_valid_q;
  psf_pkg::s1_t    s1_q;

  logic                      accept;
  logic [psf_pkg::BPP_W-1:0] bppc;
  logic [LW-1:0]             lenc;
  logic [IW-1:0]             rsum, ridx;
  logic                      left_ok, last;
  logic [7:0]                left;

  assign in_stall_o = s1_valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (cfg_i.bytes_per_pixel == '0) begin
      bppc = psf_pkg::BPP_W'(1);
    end else if (32'(cfg_i.bytes_per_pixel) > HISTORY_DEPTH) begin
      bppc = psf_pkg::BPP_W'(HISTORY_DEPTH);
    end else begin
      bppc = cfg_i.bytes_per_pixel;
    end
    if (cfg_i.line_length == '0) begin
      lenc = LW'(1);
    end else if (32'(cfg_i.line_length) > LINE_MAX) begin
      lenc = LW'(LINE_MAX);
    end else begin
      lenc = LW'(cfg_i.line_length);
    end
  end

  // A frame start puts this beat at column zero of a first row.
  always_comb begin
    col   = in_data_i.frame_start ? '0 : col_q;
    first = in_data_i.frame_start | first_q;
    hptr  = in_data_i.frame_start ? '0 : hptr_q;
  end

  // The history slot of column col-bpp is hptr-bpp, wrapped into the history depth.
  always_comb begin
    rsum = IW'(hptr) + IW'(HISTORY_DEPTH) - IW'(bppc);
    if (rsum >= IW'(HISTORY_DEPTH)) begin
      ridx = rsum - IW'(HISTORY_DEPTH);
    end else begin
      ridx = rsum;
    end
    left_ok = 32'(col) >= 32'(bppc);
    left    = left_ok ? hist_q[ridx[HW-1:0]] : 8'd0;
    last    = (LW1'(col) + LW1'(1)) >= LW1'(lenc);
  end

  always_comb begin
    col_d   = col_q;
    first_d = first_q;
    hptr_d  = hptr_q;
    if (accept) begin
      if (last) begin
        col_d   = '0;
        first_d = 1'b0;
        hptr_d  = '0;
      end else begin
        col_d   = col + CW'(1);
        first_d = first;
        hptr_d  = (hptr == HW'(HISTORY_DEPTH - 1)) ? '0 : hptr + HW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      first_q    <= 1'b1;
      hptr_q     <= '0;
      s1_valid_q <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= 8'd0;
      end
    end else begin
      col_q   <= col_d;
      first_q <= first_d;
      hptr_q  <= hptr_d;
      if (accept) begin
        hist_q[hptr] <= in_data_i.raw_byte;
        s1_valid_q   <= 1'b1;
      end else if (take_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.raw_byte  <= in_data_i.raw_byte;
      s1_q.left_byte <= left;
      s1_q.first_row <= first;
      s1_q.row_end   <= last;
    end
  end

  assign s1_valid_o  = s1_valid_q;
  assign s1_o        = s1_q;
  assign mem_en_o    = accept;
  assign mem_addr_o  = col;
  assign mem_wdata_o = in_data_i.raw_byte;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("Accepted beat did not reach the front stage register.");

  a_row_end_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last |=> col_q == '0 && !first_q && hptr_q == '0)
    else $error("Column state not cleared after the last beat of a row.");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < LINE_MAX)
    else $error("Column counter beyond the line store.");

  a_hptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(hptr_q) < HISTORY_DEPTH)
    else $error("History pointer beyond the history depth.");

endmodule

// ----- rtl/core/psf_out_stage.sv -----
// Output stage: combines raw, left and above bytes and holds the result beat.
// Depends on psf_pkg for filter codes and beat types.
module psf_out_stage (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s1_valid_i,
  input  psf_pkg::s1_t                 s1_i,
  input  logic [7:0]                   above_raw_i,
  input  logic [psf_pkg::MODE_W-1:0]   filter_mode_i,
  output logic                         take_o,
  output logic                         out_valid_o,
  output psf_pkg::out_beat_t           out_data_o,
  input  logic                         out_stall_i
);

  logic               out_valid_q;
  psf_pkg::out_beat_t out_q, out_d;
  logic [7:0]         above;
  logic [8:0]         avg_sum;

  assign take_o = s1_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    above   = s1_i.first_row ? 8'd0 : above_raw_i;
    avg_sum = {1'b0, s1_i.left_byte} + {1'b0, above};
    out_d.row_end       = s1_i.row_end;
    out_d.filtered_byte = s1_i.raw_byte;
    unique case (psf_pkg::filter_e'(filter_mode_i))
      psf_pkg::FILT_SUB:  out_d.filtered_byte = s1_i.raw_byte - s1_i.left_byte;
      psf_pkg::FILT_UP:   out_d.filtered_byte = s1_i.raw_byte - above;
      psf_pkg::FILT_AVG:  out_d.filtered_byte = s1_i.raw_byte - avg_sum[8:1];
      psf_pkg::FILT_NONE: out_d.filtered_byte = s1_i.raw_byte;
      default:            out_d.filtered_byte = s1_i.raw_byte;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_take_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |=> out_valid_q && out_q.row_end == $past(s1_i.row_end))
    else $error("Taken beat did not land in the output register.");

endmodule
